FILE: design/i2cm_pkg.sv
// shared types and constants of the i2c master transaction engine
`default_nettype none
package i2cm_pkg;
  localparam int MaxBytes = 16;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_BEGIN = 2'd2;

  localparam logic [2:0] K_REG_WR = 3'd0;
  localparam logic [2:0] K_STR_WR = 3'd1;
  localparam logic [2:0] K_REG_RD = 3'd2;
  localparam logic [2:0] K_STR_RD = 3'd3;
  localparam logic [2:0] K_STR_RD_NS = 3'd4;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_START1 = 4'd1;
  localparam logic [3:0] ST_ADDR1 = 4'd2;
  localparam logic [3:0] ST_ACK1 = 4'd3;
  localparam logic [3:0] ST_REG = 4'd4;
  localparam logic [3:0] ST_ACKREG = 4'd5;
  localparam logic [3:0] ST_DATA = 4'd6;
  localparam logic [3:0] ST_ACKDATA = 4'd7;
  localparam logic [3:0] ST_START2 = 4'd8;
  localparam logic [3:0] ST_ADDR2 = 4'd9;
  localparam logic [3:0] ST_ACK2 = 4'd10;
  localparam logic [3:0] ST_RX = 4'd11;
  localparam logic [3:0] ST_MACK = 4'd12;
  localparam logic [3:0] ST_STOPOK = 4'd13;
  localparam logic [3:0] ST_STOPFAIL = 4'd14;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0] op;
    logic [2:0] kind;
    logic [7:0] slave_addr;
    logic [7:0] data_byte;
    logic [4:0] length;
    logic       sda_in;
  } item_t;

  // one result item
  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_enable;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic       success;
    logic       busy_res;
  } res_t;
endpackage
`default_nettype wire

FILE: design/i2cm_front.sv
// input stage and two-entry queue feeding the bus sequencer
`default_nettype none
module i2cm_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire i2cm_pkg::item_t in_item,
  output logic                q_valid,
  input  wire logic           q_ready,
  output i2cm_pkg::item_t     q_item
);
  i2cm_pkg::item_t slot [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item = slot[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: design/i2cm_back.sv
// bus sequencer: runs one item per cycle while its result register is free or being taken, and registers its result
`default_nettype none
module i2cm_back #(
  parameter int MAX_BYTES = i2cm_pkg::MaxBytes
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire i2cm_pkg::item_t q_item,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output i2cm_pkg::res_t       res
);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW = $clog2(MAX_BYTES + 1);

  logic [7:0] device_addr, retry_limit;
  logic [3:0] stage, stage_next;
  logic [1:0] phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] retry_count, retry_count_next;
  logic [2:0] cur_kind;
  logic [7:0] cur_addr, cur_data, cur_length;
  logic [CW-1:0] load_count;
  logic [7:0] write_buffer [MAX_BYTES];
  logic       o_scl, o_sda, o_en, scl_next, sda_next, en_next;
  i2cm_pkg::res_t res_next;
  logic       fire;
  logic       is_tick;
  logic       ack, last;
  logic [7:0] first_addr, len_sat;
  logic [7:0] buf_rd;

  assign q_ready = !res_valid || res_ready;
  assign fire = q_valid && q_ready;
  assign is_tick = (q_item.op != i2cm_pkg::OP_LOAD) && (q_item.op != i2cm_pkg::OP_BEGIN);
  assign last = (phase == 2'd3);

  function automatic logic [7:0] buf_at(input logic [7:0] idx,
                                         input logic [7:0] bv);
    buf_at = (idx < 8'(MAX_BYTES)) ? bv : 8'd0;
  endfunction

  always_comb begin
    buf_rd = write_buffer[byte_index_next[AW-1:0]];
    if (cur_kind == i2cm_pkg::K_REG_WR || cur_kind == i2cm_pkg::K_REG_RD)
      first_addr = device_addr;
    else if (cur_kind == i2cm_pkg::K_STR_WR) first_addr = cur_addr;
    else first_addr = cur_addr + 8'd1;
    len_sat = ({3'd0, q_item.length} > 8'(MAX_BYTES)) ? 8'(MAX_BYTES)
                                                        : {3'd0, q_item.length};
    if (q_item.kind == i2cm_pkg::K_REG_RD) len_sat = 8'd1;
    if (q_item.kind == i2cm_pkg::K_STR_RD && len_sat == 8'd0) len_sat = 8'd1;
  end

  // one quarter-bit phase of the bus
  always_comb begin
    stage_next = stage;
    phase_next = phase + 2'd1;
    bit_count_next = bit_count;
    shift_reg_next = shift_reg;
    byte_index_next = byte_index;
    retry_count_next = retry_count;
    scl_next = o_scl;
    sda_next = o_sda;
    en_next = o_en;
    res_next = '0;
    ack = 1'b0;
    case (stage)
      i2cm_pkg::ST_START1, i2cm_pkg::ST_START2: begin
        en_next = 1'b1;
        case (phase)
          2'd0: sda_next = 1'b1;
          2'd1: begin sda_next = 1'b1; scl_next = 1'b1; end
          2'd2: begin sda_next = 1'b0; scl_next = 1'b1; end
          default: begin
            sda_next = 1'b0; scl_next = 1'b0; bit_count_next = 4'd0;
            if (stage == i2cm_pkg::ST_START1) begin
              stage_next = i2cm_pkg::ST_ADDR1; shift_reg_next = first_addr;
            end else begin
              stage_next = i2cm_pkg::ST_ADDR2; shift_reg_next = device_addr + 8'd1;
            end
          end
        endcase
      end
      i2cm_pkg::ST_ADDR1, i2cm_pkg::ST_REG, i2cm_pkg::ST_DATA,
      i2cm_pkg::ST_ADDR2: begin
        en_next = 1'b1;
        sda_next = shift_reg[3'd7 - bit_count[2:0]];
        scl_next = (phase == 2'd1 || phase == 2'd2);
        if (last) begin
          bit_count_next = bit_count + 4'd1;
          if (bit_count_next >= 4'd8) begin
            bit_count_next = 4'd0; stage_next = stage + 4'd1;
          end
        end
      end
      i2cm_pkg::ST_ACK1, i2cm_pkg::ST_ACKREG, i2cm_pkg::ST_ACKDATA,
      i2cm_pkg::ST_ACK2: begin
        en_next = 1'b0; sda_next = 1'b1;
        scl_next = (phase == 2'd1 || phase == 2'd2);
        if (phase == 2'd2) shift_reg_next = {7'd0, !q_item.sda_in};
        ack = shift_reg[0];
        if (last) begin
          if (stage == i2cm_pkg::ST_ACK1 || stage == i2cm_pkg::ST_ACK2) begin
            if (!ack) begin
              retry_count_next = retry_count + 8'd1;
              stage_next = (retry_count > retry_limit) ? i2cm_pkg::ST_STOPFAIL :
                (stage == i2cm_pkg::ST_ACK1) ? i2cm_pkg::ST_START1
                                             : i2cm_pkg::ST_START2;
            end else if (stage == i2cm_pkg::ST_ACK2) begin
              byte_index_next = 8'd0; bit_count_next = 4'd0;
              shift_reg_next = 8'd0; stage_next = i2cm_pkg::ST_RX;
            end else if (cur_kind == i2cm_pkg::K_REG_WR
                         || cur_kind == i2cm_pkg::K_REG_RD) begin
              stage_next = i2cm_pkg::ST_REG; shift_reg_next = cur_addr;
            end else if (cur_kind == i2cm_pkg::K_STR_WR) begin
              byte_index_next = 8'd0;
              if (cur_length != 8'd0) begin
                stage_next = i2cm_pkg::ST_DATA;
                shift_reg_next = buf_at(8'd0, buf_rd);
              end else stage_next = i2cm_pkg::ST_STOPOK;
            end else begin
              byte_index_next = 8'd0; bit_count_next = 4'd0; shift_reg_next = 8'd0;
              if (cur_length != 8'd0) stage_next = i2cm_pkg::ST_RX;
              else begin
                stage_next = i2cm_pkg::ST_IDLE;
                res_next.done_res = 1'b1; res_next.success = 1'b1;
              end
            end
          end else if (stage == i2cm_pkg::ST_ACKREG) begin
            if (!ack) stage_next = i2cm_pkg::ST_STOPFAIL;
            else if (cur_kind == i2cm_pkg::K_REG_WR) begin
              stage_next = i2cm_pkg::ST_DATA; shift_reg_next = cur_data;
            end else stage_next = i2cm_pkg::ST_START2;
          end else begin
            if (!ack) stage_next = i2cm_pkg::ST_STOPFAIL;
            else if (cur_kind == i2cm_pkg::K_STR_WR) begin
              byte_index_next = byte_index + 8'd1;
              if (byte_index_next < cur_length) begin
                stage_next = i2cm_pkg::ST_DATA;
                shift_reg_next = buf_at(byte_index_next, buf_rd);
              end else stage_next = i2cm_pkg::ST_STOPOK;
            end else stage_next = i2cm_pkg::ST_STOPOK;
          end
        end
      end
      i2cm_pkg::ST_RX: begin
        en_next = 1'b0; sda_next = 1'b1;
        scl_next = (phase == 2'd1 || phase == 2'd2);
        if (phase == 2'd2) begin
          shift_reg_next = {shift_reg[6:0], q_item.sda_in};
          if (bit_count == 4'd7) begin
            res_next.read_byte = shift_reg_next; res_next.read_valid = 1'b1;
          end
        end
        if (last) begin
          bit_count_next = bit_count + 4'd1;
          if (bit_count_next >= 4'd8) begin
            bit_count_next = 4'd0; stage_next = i2cm_pkg::ST_MACK;
          end
        end
      end
      i2cm_pkg::ST_MACK: begin
        en_next = 1'b1;
        sda_next = (cur_kind != i2cm_pkg::K_STR_RD_NS)
                   && ({1'b0, byte_index} + 9'd1 >= {1'b0, cur_length});
        scl_next = (phase == 2'd1 || phase == 2'd2);
        if (last) begin
          byte_index_next = byte_index + 8'd1;
          shift_reg_next = 8'd0; bit_count_next = 4'd0;
          if (byte_index_next < cur_length) stage_next = i2cm_pkg::ST_RX;
          else if (cur_kind == i2cm_pkg::K_STR_RD_NS) begin
            stage_next = i2cm_pkg::ST_IDLE;
            res_next.done_res = 1'b1; res_next.success = 1'b1;
          end else stage_next = i2cm_pkg::ST_STOPOK;
        end
      end
      i2cm_pkg::ST_STOPOK, i2cm_pkg::ST_STOPFAIL: begin
        en_next = 1'b1;
        case (phase)
          2'd0: sda_next = 1'b0;
          2'd1: begin sda_next = 1'b0; scl_next = 1'b1; end
          default: begin sda_next = 1'b1; scl_next = 1'b1; end
        endcase
        if (last) begin
          res_next.done_res = 1'b1;
          res_next.success = (stage == i2cm_pkg::ST_STOPOK);
          stage_next = i2cm_pkg::ST_IDLE;
        end
      end
      default: begin
        stage_next = i2cm_pkg::ST_IDLE; phase_next = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire && q_item.op == i2cm_pkg::OP_LOAD && stage == i2cm_pkg::ST_IDLE
        && load_count < CW'(MAX_BYTES)) begin
      write_buffer[load_count[AW-1:0]] <= q_item.data_byte;
    end
    if (fire && q_item.op == i2cm_pkg::OP_BEGIN && stage == i2cm_pkg::ST_IDLE
        && q_item.kind <= i2cm_pkg::K_STR_RD_NS) begin
      cur_kind <= q_item.kind;
      cur_addr <= q_item.slave_addr;
      cur_data <= q_item.data_byte;
      cur_length <= len_sat;
    end
    if (fire) begin
      if (is_tick && stage != i2cm_pkg::ST_IDLE) begin
        res.read_byte <= res_next.read_byte;
        res.read_valid <= res_next.read_valid;
        res.done_res <= res_next.done_res;
        res.success <= res_next.success;
      end else begin
        res.read_byte <= '0; res.read_valid <= 1'b0;
        res.done_res <= 1'b0; res.success <= 1'b0;
      end
    end
    if (rst) begin
      device_addr <= 8'd0; retry_limit <= 8'd3;
      stage <= i2cm_pkg::ST_IDLE; phase <= 2'd0; bit_count <= 4'd0;
      shift_reg <= 8'd0; byte_index <= 8'd0; retry_count <= 8'd0;
      load_count <= '0; o_scl <= 1'b1; o_sda <= 1'b1; o_en <= 1'b1;
      res_valid <= 1'b0;
      res.scl <= 1'b1; res.sda_level <= 1'b1; res.sda_enable <= 1'b1;
      res.busy_res <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) retry_limit <= cfg_data;
        else device_addr <= cfg_data;
      end
      if (fire) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (fire) begin
        if (q_item.op == i2cm_pkg::OP_LOAD) begin
          if (stage == i2cm_pkg::ST_IDLE && load_count < CW'(MAX_BYTES))
            load_count <= load_count + CW'(1);
          res.busy_res <= (stage != i2cm_pkg::ST_IDLE);
        end else if (q_item.op == i2cm_pkg::OP_BEGIN) begin
          if (stage == i2cm_pkg::ST_IDLE && q_item.kind <= i2cm_pkg::K_STR_RD_NS) begin
            retry_count <= 8'd0; byte_index <= 8'd0; bit_count <= 4'd0;
            shift_reg <= 8'd0; phase <= 2'd0; load_count <= '0;
            stage <= i2cm_pkg::ST_START1;
            res.busy_res <= 1'b1;
          end else res.busy_res <= (stage != i2cm_pkg::ST_IDLE);
        end else if (stage != i2cm_pkg::ST_IDLE) begin
          stage <= stage_next; phase <= phase_next; bit_count <= bit_count_next;
          shift_reg <= shift_reg_next; byte_index <= byte_index_next;
          retry_count <= retry_count_next;
          o_scl <= scl_next; o_sda <= sda_next; o_en <= en_next;
          res.scl <= scl_next; res.sda_level <= sda_next; res.sda_enable <= en_next;
          res.busy_res <= (stage_next != i2cm_pkg::ST_IDLE);
        end else res.busy_res <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/i2c_master_transaction_engine_unit.sv
// top level of the i2c master transaction engine
// I2C master sequencer stepped by items: a tick item advances a busy bus by one
// quarter bit, a load item appends a byte to the write buffer while idle and
// not full, and a begin item while idle starts a register write, string write,
// register read, string read, or string read without stop. Every item yields
// exactly one result item carrying the line drive (scl, sda_level, sda_enable),
// any received byte, the done and success flags and busy. A new item is taken
// every cycle while the queue is not full: a two-entry queue in front
// decouples the input from the sequencer, and the sequencer's result register
// holds a finished result until it is taken. An item passes through the queue
// register, then the sequencer's result register. While a result waits the
// sequencer stalls and the queue absorbs up to two more items before the input
// stalls. Throughput is set by the sequencer step.
`default_nettype none
module i2c_master_transaction_engine_unit #(
  parameter int MAX_BYTES = i2cm_pkg::MaxBytes
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] op,
  input  wire logic [2:0] kind,
  input  wire logic [7:0] slave_addr,
  input  wire logic [7:0] data_byte,
  input  wire logic [4:0] length,
  input  wire logic       sda_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            scl,
  output logic            sda_level,
  output logic            sda_enable,
  output logic [7:0]      read_byte,
  output logic            read_valid,
  output logic            done_res,
  output logic            success,
  output logic            busy_res
);
  i2cm_pkg::item_t in_item, q_item;
  i2cm_pkg::res_t  res;
  logic q_valid, q_ready;

  // pack the item fields
  always_comb begin
    in_item.op = op;
    in_item.kind = kind;
    in_item.slave_addr = slave_addr;
    in_item.data_byte = data_byte;
    in_item.length = length;
    in_item.sda_in = sda_in;
  end

  i2cm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  i2cm_back #(.MAX_BYTES(MAX_BYTES)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .res_valid(out_valid), .res_ready(out_ready), .res(res)
  );

  // unpack the result fields
  assign scl = res.scl;
  assign sda_level = res.sda_level;
  assign sda_enable = res.sda_enable;
  assign read_byte = res.read_byte;
  assign read_valid = res.read_valid;
  assign done_res = res.done_res;
  assign success = res.success;
  assign busy_res = res.busy_res;
endmodule
`default_nettype wire

FILE: design/i2cm_checker.sv
// port-level checker for the i2c master transaction engine
`default_nettype none
module i2cm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       sda_level,
  input wire logic       sda_enable,
  input wire logic       done_res,
  input wire logic       success,
  input wire logic       read_valid,
  input wire logic [7:0] read_byte,
  input wire logic       busy_res
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(busy_res))
    else $error("result dropped while stalled");
  a_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sda_enable |-> sda_level)
    else $error("released sda not high");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done while still busy");
  a_success: assert property (@(posedge clk) disable iff (rst)
    out_valid && success |-> done_res)
    else $error("success without done");
  a_rbyte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> read_byte == 8'd0)
    else $error("stray read byte");
endmodule

bind i2c_master_transaction_engine_unit i2cm_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .sda_level(sda_level), .sda_enable(sda_enable), .done_res(done_res),
  .success(success), .read_valid(read_valid), .read_byte(read_byte),
  .busy_res(busy_res)
);
`default_nettype wire

FILE: test/i2c_master_transaction_engine_unit_test.sv
// testbench of the i2c master transaction engine: predicted results against the block
`timescale 1ns / 100ps
`default_nettype none
module i2c_master_transaction_engine_unit_test;
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] op = i2cm_pkg::OP_TICK;
  logic [2:0] kind = i2cm_pkg::K_REG_WR;
  logic [7:0] slave_addr = 8'd0;
  logic [7:0] data_byte = 8'd0;
  logic [4:0] length = 5'd0;
  logic       sda_in = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl, sda_level, sda_enable, read_valid, done_res, success, busy_res;
  logic [7:0] read_byte;

  localparam logic CFG_DEV_ADDR = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  i2c_master_transaction_engine_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .kind(kind),
    .slave_addr(slave_addr), .data_byte(data_byte), .length(length), .sda_in(sda_in),
    .out_valid(out_valid), .out_ready(out_ready), .scl(scl), .sda_level(sda_level),
    .sda_enable(sda_enable), .read_byte(read_byte), .read_valid(read_valid),
    .done_res(done_res), .success(success), .busy_res(busy_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // predictor state, mirrors the sequencer
  logic [7:0] p_dev, p_limit;
  logic [3:0] p_stage;
  logic [1:0] p_phase;
  logic [3:0] p_bits;
  logic [7:0] p_shift;
  logic [4:0] p_idx;
  logic [7:0] p_retry;
  logic [2:0] p_kind;
  logic [7:0] p_addr, p_data;
  logic [4:0] p_len, p_loads;
  logic [7:0] p_buf [i2cm_pkg::MaxBytes];
  logic       p_scl, p_sda, p_en;

  i2cm_pkg::res_t expected_results[$];
  int   fail_count = 0;
  int   items_sent = 0;
  bit   long_hold = 1'b0;

  // bus model of the slave side: ack or nack each ack slot
  int   nack_pct = 0;

  function automatic logic [7:0] first_address();
    if (p_kind == i2cm_pkg::K_REG_WR || p_kind == i2cm_pkg::K_REG_RD) return p_dev;
    if (p_kind == i2cm_pkg::K_STR_WR) return p_addr;
    return p_addr + 8'd1;
  endfunction

  function automatic void address_nacked(logic [3:0] restart);
    logic [7:0] old;
    old = p_retry;
    p_retry = p_retry + 8'd1;
    p_stage = (old > p_limit) ? i2cm_pkg::ST_STOPFAIL : restart;
  endfunction

  // one quarter-bit phase of the bus
  function automatic void bus_phase(logic sda, inout i2cm_pkg::res_t r);
    logic [1:0] ph;
    logic       last, ack;
    ph = p_phase;
    last = (ph == 2'd3);
    p_phase = p_phase + 2'd1;
    case (p_stage)
      i2cm_pkg::ST_START1, i2cm_pkg::ST_START2: begin
        p_en = 1'b1;
        if (ph == 2'd0) p_sda = 1'b1;
        else if (ph == 2'd1) begin p_sda = 1'b1; p_scl = 1'b1; end
        else if (ph == 2'd2) begin p_sda = 1'b0; p_scl = 1'b1; end
        else begin
          p_sda = 1'b0; p_scl = 1'b0; p_bits = 4'd0;
          if (p_stage == i2cm_pkg::ST_START1) begin
            p_stage = i2cm_pkg::ST_ADDR1; p_shift = first_address();
          end else begin
            p_stage = i2cm_pkg::ST_ADDR2; p_shift = p_dev + 8'd1;
          end
        end
      end
      i2cm_pkg::ST_ADDR1, i2cm_pkg::ST_REG, i2cm_pkg::ST_DATA,
      i2cm_pkg::ST_ADDR2: begin
        p_en = 1'b1;
        p_sda = p_shift[7 - p_bits[2:0]];
        p_scl = (ph == 2'd1 || ph == 2'd2);
        if (last) begin
          p_bits = p_bits + 4'd1;
          if (p_bits >= 4'd8) begin p_bits = 4'd0; p_stage = p_stage + 4'd1; end
        end
      end
      i2cm_pkg::ST_ACK1, i2cm_pkg::ST_ACKREG, i2cm_pkg::ST_ACKDATA,
      i2cm_pkg::ST_ACK2: begin
        p_en = 1'b0; p_sda = 1'b1;
        p_scl = (ph == 2'd1 || ph == 2'd2);
        if (ph == 2'd2) p_shift = sda ? 8'd0 : 8'd1;
        if (last) begin
          ack = p_shift[0];
          if (p_stage == i2cm_pkg::ST_ACK1) begin
            if (!ack) address_nacked(i2cm_pkg::ST_START1);
            else if (p_kind == i2cm_pkg::K_REG_WR || p_kind == i2cm_pkg::K_REG_RD) begin
              p_stage = i2cm_pkg::ST_REG; p_shift = p_addr;
            end else if (p_kind == i2cm_pkg::K_STR_WR) begin
              p_idx = 5'd0;
              if (p_len > 0) begin p_stage = i2cm_pkg::ST_DATA; p_shift = p_buf[0]; end
              else p_stage = i2cm_pkg::ST_STOPOK;
            end else begin
              p_idx = 5'd0; p_bits = 4'd0; p_shift = 8'd0;
              if (p_len > 0) p_stage = i2cm_pkg::ST_RX;
              else begin
                p_stage = i2cm_pkg::ST_IDLE; r.done_res = 1'b1; r.success = 1'b1;
              end
            end
          end else if (p_stage == i2cm_pkg::ST_ACKREG) begin
            if (!ack) p_stage = i2cm_pkg::ST_STOPFAIL;
            else if (p_kind == i2cm_pkg::K_REG_WR) begin
              p_stage = i2cm_pkg::ST_DATA; p_shift = p_data;
            end else p_stage = i2cm_pkg::ST_START2;
          end else if (p_stage == i2cm_pkg::ST_ACKDATA) begin
            if (!ack) p_stage = i2cm_pkg::ST_STOPFAIL;
            else if (p_kind == i2cm_pkg::K_STR_WR) begin
              p_idx = p_idx + 5'd1;
              if (p_idx < p_len) begin
                p_stage = i2cm_pkg::ST_DATA; p_shift = p_buf[p_idx[3:0]];
              end else p_stage = i2cm_pkg::ST_STOPOK;
            end else p_stage = i2cm_pkg::ST_STOPOK;
          end else begin
            if (!ack) address_nacked(i2cm_pkg::ST_START2);
            else begin
              p_idx = 5'd0; p_bits = 4'd0; p_shift = 8'd0; p_stage = i2cm_pkg::ST_RX;
            end
          end
        end
      end
      i2cm_pkg::ST_RX: begin
        p_en = 1'b0; p_sda = 1'b1;
        p_scl = (ph == 2'd1 || ph == 2'd2);
        if (ph == 2'd2) begin
          p_shift = {p_shift[6:0], sda};
          if (p_bits == 4'd7) begin r.read_byte = p_shift; r.read_valid = 1'b1; end
        end
        if (last) begin
          p_bits = p_bits + 4'd1;
          if (p_bits >= 4'd8) begin p_bits = 4'd0; p_stage = i2cm_pkg::ST_MACK; end
        end
      end
      i2cm_pkg::ST_MACK: begin
        p_en = 1'b1;
        p_sda = (p_kind != i2cm_pkg::K_STR_RD_NS && ({1'b0, p_idx} + 6'd1 >= {1'b0, p_len}));
        p_scl = (ph == 2'd1 || ph == 2'd2);
        if (last) begin
          p_idx = p_idx + 5'd1; p_shift = 8'd0; p_bits = 4'd0;
          if (p_idx < p_len) p_stage = i2cm_pkg::ST_RX;
          else if (p_kind == i2cm_pkg::K_STR_RD_NS) begin
            p_stage = i2cm_pkg::ST_IDLE; r.done_res = 1'b1; r.success = 1'b1;
          end else p_stage = i2cm_pkg::ST_STOPOK;
        end
      end
      i2cm_pkg::ST_STOPOK, i2cm_pkg::ST_STOPFAIL: begin
        p_en = 1'b1;
        if (ph == 2'd0) p_sda = 1'b0;
        else if (ph == 2'd1) begin p_sda = 1'b0; p_scl = 1'b1; end
        else begin p_sda = 1'b1; p_scl = 1'b1; end
        if (last) begin
          r.done_res = 1'b1; r.success = (p_stage == i2cm_pkg::ST_STOPOK);
          p_stage = i2cm_pkg::ST_IDLE;
        end
      end
      default: begin p_stage = i2cm_pkg::ST_IDLE; p_phase = 2'd0; end
    endcase
  endfunction

  // result that the engine owes for one item
  function automatic i2cm_pkg::res_t engine_result(i2cm_pkg::item_t it);
    i2cm_pkg::res_t r;
    logic [4:0] n;
    r = '0;
    if (it.op == i2cm_pkg::OP_LOAD) begin
      if (p_stage == i2cm_pkg::ST_IDLE && p_loads < i2cm_pkg::MaxBytes) begin
        p_buf[p_loads[3:0]] = it.data_byte;
        p_loads = p_loads + 5'd1;
      end
    end else if (it.op == i2cm_pkg::OP_BEGIN) begin
      if (p_stage == i2cm_pkg::ST_IDLE && it.kind <= i2cm_pkg::K_STR_RD_NS) begin
        n = (it.length > i2cm_pkg::MaxBytes) ? 5'(i2cm_pkg::MaxBytes) : it.length;
        if (it.kind == i2cm_pkg::K_REG_RD) n = 5'd1;
        if (it.kind == i2cm_pkg::K_STR_RD && n == 0) n = 5'd1;
        p_kind = it.kind; p_addr = it.slave_addr; p_data = it.data_byte; p_len = n;
        p_retry = 8'd0; p_idx = 5'd0; p_bits = 4'd0; p_shift = 8'd0;
        p_phase = 2'd0; p_loads = 5'd0; p_stage = i2cm_pkg::ST_START1;
      end
    end else if (p_stage != i2cm_pkg::ST_IDLE) begin
      bus_phase(it.sda_in, r);
    end
    r.scl = p_scl; r.sda_level = p_sda; r.sda_enable = p_en;
    r.busy_res = (p_stage != i2cm_pkg::ST_IDLE);
    return r;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;

  task automatic send_item(i2cm_pkg::item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= it.op; kind <= it.kind; slave_addr <= it.slave_addr;
    data_byte <= it.data_byte; length <= it.length; sda_in <= it.sda_in;
    expected_results.push_back(engine_result(it));
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver: own stall pattern, plus one long hold-off
  int stall_mode = 0;
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) out_ready <= 1'b0;
      else case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) == 0);
      endcase
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    end
  end

  // checker of each accepted result item
  always @(posedge clk) begin
    i2cm_pkg::res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (scl !== e.scl) begin
          $error("scl expected %0d got %0d", e.scl, scl); fail_count++;
        end
        if (sda_level !== e.sda_level) begin
          $error("sda_level expected %0d got %0d", e.sda_level, sda_level); fail_count++;
        end
        if (sda_enable !== e.sda_enable) begin
          $error("sda_enable expected %0d got %0d", e.sda_enable, sda_enable); fail_count++;
        end
        if (read_byte !== e.read_byte) begin
          $error("read_byte expected %0h got %0h", e.read_byte, read_byte); fail_count++;
        end
        if (read_valid !== e.read_valid) begin
          $error("read_valid expected %0d got %0d", e.read_valid, read_valid); fail_count++;
        end
        if (done_res !== e.done_res) begin
          $error("done_res expected %0d got %0d", e.done_res, done_res); fail_count++;
        end
        if (success !== e.success) begin
          $error("success expected %0d got %0d", e.success, success); fail_count++;
        end
        if (busy_res !== e.busy_res) begin
          $error("busy_res expected %0d got %0d", e.busy_res, busy_res); fail_count++;
        end
      end
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEV_ADDR) p_dev = val; else p_limit = val;
  endtask

  function automatic i2cm_pkg::item_t mk(logic [1:0] o, logic [2:0] k, logic [7:0] a,
                                         logic [7:0] d, logic [4:0] n, logic s);
    i2cm_pkg::item_t it;
    it.op = o; it.kind = k; it.slave_addr = a; it.data_byte = d;
    it.length = n; it.sda_in = s;
    return it;
  endfunction

  // slave line: nack on ack slots at nack_pct, random data otherwise
  function automatic logic slave_line();
    if (p_stage == i2cm_pkg::ST_ACK1 || p_stage == i2cm_pkg::ST_ACKREG ||
        p_stage == i2cm_pkg::ST_ACKDATA || p_stage == i2cm_pkg::ST_ACK2)
      return ($urandom_range(0, 99) < nack_pct);
    return 1'($urandom_range(0, 1));
  endfunction

  // run a whole transaction: loads, begin, ticks until idle
  task automatic run_transaction(logic [2:0] k, logic [7:0] a, logic [7:0] d,
                                 logic [4:0] n, int loads);
    for (int i = 0; i < loads; i++)
      send_item(mk(i2cm_pkg::OP_LOAD, 3'($urandom_range(0, 7)), 8'($urandom),
                   8'($urandom), 5'($urandom), 1'($urandom)));
    send_item(mk(i2cm_pkg::OP_BEGIN, k, a, d, n, 1'($urandom)));
    while (p_stage != i2cm_pkg::ST_IDLE) begin
      // occasional noise: load or begin while busy, op 3
      if ($urandom_range(0, 29) == 0)
        send_item(mk(2'($urandom_range(1, 3)), 3'($urandom), 8'($urandom), 8'($urandom),
                     5'($urandom), slave_line()));
      else
        send_item(mk(i2cm_pkg::OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom),
                     5'($urandom), slave_line()));
    end
  endtask

  // string writes never read past the loaded bytes
  task automatic random_transaction();
    logic [2:0] k;
    logic [4:0] n;
    k = 3'($urandom_range(0, 4));
    n = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 4));
    if (k == i2cm_pkg::K_STR_WR)
      run_transaction(k, 8'($urandom), 8'($urandom), n,
                      (n > i2cm_pkg::MaxBytes) ? i2cm_pkg::MaxBytes : int'(n));
    else run_transaction(k, 8'($urandom), 8'($urandom), n, $urandom_range(0, 2));
  endtask

  task automatic test_directed();
    // idle ticks hold outputs, illegal kind and op 3 are ignored
    send_item(mk(i2cm_pkg::OP_TICK, i2cm_pkg::K_REG_WR, 8'h00, 8'h00, 5'd0, 1'b0));
    send_item(mk(2'd3, 3'd7, 8'hff, 8'hff, 5'd31, 1'b1));
    send_item(mk(i2cm_pkg::OP_BEGIN, 3'd5, 8'hff, 8'hff, 5'd31, 1'b1));
    send_item(mk(i2cm_pkg::OP_BEGIN, 3'd7, 8'h00, 8'h00, 5'd0, 1'b0));
    nack_pct = 0;
    // loads past a full buffer are dropped
    run_transaction(i2cm_pkg::K_STR_WR, 8'hff, 8'h55, 5'd2, i2cm_pkg::MaxBytes + 2);
    run_transaction(i2cm_pkg::K_STR_WR, 8'h00, 8'hff, 5'd0, 0);
    run_transaction(i2cm_pkg::K_STR_RD, 8'hff, 8'h00, 5'd0, 1);
    run_transaction(i2cm_pkg::K_STR_RD_NS, 8'h7f, 8'h00, 5'd0, 0);
    run_transaction(i2cm_pkg::K_REG_RD, 8'h80, 8'h01, 5'd9, 0);
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    fork
      begin
        nack_pct = 0;
        run_transaction(i2cm_pkg::K_REG_WR, 8'h3c, 8'ha5, 5'd0, 0);
      end
      begin
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end
    join
  endtask

  task automatic test_retries();
    // address nacks exhaust a zero retry limit with device address 0xff
    drain();
    write_reg(CFG_RETRY_LIMIT, 8'd0);
    write_reg(CFG_DEV_ADDR, 8'hff);
    nack_pct = 100;
    run_transaction(i2cm_pkg::K_REG_RD, 8'h10, 8'h00, 5'd1, 0);
  endtask

  task automatic test_random();
    logic [7:0] limits [4];
    int sel;
    limits = '{8'd0, 8'd1, 8'd3, 8'd255};
    while (items_sent < 700) begin
      drain();
      sel = $urandom_range(0, 3);
      write_reg(CFG_RETRY_LIMIT, limits[sel]);
      write_reg(CFG_DEV_ADDR, 8'($urandom));
      // a wrapping counter must not see endless nacks
      nack_pct = (limits[sel] == 8'd255) ? 20 : $urandom_range(0, 60);
      random_transaction();
    end
  endtask

  initial begin
    p_dev = 8'd0; p_limit = 8'd3; p_stage = i2cm_pkg::ST_IDLE; p_phase = 2'd0;
    p_bits = 4'd0; p_shift = 8'd0; p_idx = 5'd0; p_retry = 8'd0; p_kind = 3'd0;
    p_addr = 8'd0; p_data = 8'd0; p_len = 5'd0; p_loads = 5'd0;
    p_scl = 1'b1; p_sda = 1'b1; p_en = 1'b1;
    foreach (p_buf[i]) p_buf[i] = 8'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_retries();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: i2c_master_transaction_engine_unit.f
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_back.sv
design/i2c_master_transaction_engine_unit.sv
design/i2cm_checker.sv
test/i2c_master_transaction_engine_unit_test.sv
